>>> rtl/hcg_pkg.sv
package hcg_pkg;

    localparam int MaxKeys = 8;
    localparam int KeyAw   = $clog2(MaxKeys);
    localparam int CntW    = 4;
    localparam int DivSteps = 17;
    localparam logic signed [31:0] QOne   = 32'sd65536;
    localparam logic signed [33:0] SegEps = 34'sd7;

    typedef enum logic [1:0] {
        OP_WR_COLOR = 2'd0,
        OP_WR_ALPHA = 2'd1,
        OP_EVAL     = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    localparam logic REG_COLOR_CNT = 1'b0;
    localparam logic REG_ALPHA_CNT = 1'b1;

    typedef enum logic [3:0] {
        MS_UU, MS_U2U, MS_S0DT, MS_S1DT,
        MS_H00V0, MS_H01V1, MS_H10M0L, MS_H10M0H, MS_H11M1L, MS_H11M1H
    } mul_code_t;

    typedef enum logic {
        SRC_PREV,
        SRC_RD
    } key_src_t;

    typedef struct packed {
        logic [31:0]      tkey;
        logic [2:0][31:0] val;
        logic [31:0]      in_s;
        logic [31:0]      out_s;
    } key_row_t;

    typedef struct packed {
        logic             load_row;
        logic             init_res;
        logic             tbl;
        logic             rd_en;
        logic [KeyAw-1:0] rd_addr;
        logic             key_wr;
        key_src_t         key_src;
        logic             div_start;
        logic             div_step;
        logic             mul_go;
        mul_code_t        mul_code;
        logic [1:0]       ch;
        logic             acc_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic t_le_rd;
        logic t_ge_rd;
        logic seg_hit;
        logic seg_short;
    } dp_stat_t;

endpackage

>>> rtl/hermite_color_gradient_eval_core.sv
// Key writes produce no result; the input is ready again next cycle.
// An evaluate, per table, searches the keys with registered RAM reads (first key, last key,
// then a scan from key 0), runs a restoring divider, and forms its products on one shared
// 34x34 multiplier (4 per table plus 6 per channel).
// One evaluate at a time; the result sits in an output register while the next runs.
// aresetn (synchronous, active low) clears both key counts and all control; key RAMs keep contents.
module hermite_color_gradient_eval_core
    import hcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic [2:0]         s_key_index,
    input  logic signed [31:0] s_key_time,
    input  logic signed [31:0] s_key_red,
    input  logic signed [31:0] s_key_green,
    input  logic signed [31:0] s_key_blue,
    input  logic signed [31:0] s_key_alpha,
    input  logic signed [31:0] s_in_tangent,
    input  logic signed [31:0] s_out_tangent,
    input  logic signed [31:0] s_eval_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_red,
    output logic signed [31:0] m_green,
    output logic signed [31:0] m_blue,
    output logic signed [31:0] m_alpha
);

    logic [CntW-1:0]  color_cnt_reg;
    logic [CntW-1:0]  alpha_cnt_reg;
    logic             m_valid_reg;
    logic [3:0][31:0] m_data_reg;

    logic             s_accept;
    logic             eval_go;
    logic             wr_color;
    logic             wr_alpha;
    logic             out_free;
    logic             out_load;
    logic             ctl_idle;
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [3:0][31:0] res;

    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == REG_ALPHA_CNT) ? 32'(alpha_cnt_reg) : 32'(color_cnt_reg);
    assign s_ready  = ctl_idle;
    assign s_accept = s_valid && s_ready;
    assign eval_go  = s_accept && (s_opcode == OP_EVAL);
    assign wr_color = s_accept && (s_opcode == OP_WR_COLOR);
    assign wr_alpha = s_accept && (s_opcode == OP_WR_ALPHA);
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_cnt_reg <= '0;
            alpha_cnt_reg <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_COLOR_CNT) begin
                color_cnt_reg <= pwdata[CntW-1:0];
            end else begin
                alpha_cnt_reg <= pwdata[CntW-1:0];
            end
        end
    end

    hcg_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .eval_go   (eval_go),
        .color_cnt (color_cnt_reg),
        .alpha_cnt (alpha_cnt_reg),
        .stat      (stat),
        .out_free  (out_free),
        .cmd       (cmd),
        .ctl_idle  (ctl_idle),
        .out_load  (out_load)
    );

    hcg_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr_color    (wr_color),
        .wr_alpha    (wr_alpha),
        .wr_addr     (KeyAw'(s_key_index)),
        .key_time    (s_key_time),
        .key_red     (s_key_red),
        .key_green   (s_key_green),
        .key_blue    (s_key_blue),
        .key_alpha   (s_key_alpha),
        .in_tangent  (s_in_tangent),
        .out_tangent (s_out_tangent),
        .eval_time   (s_eval_time),
        .cmd         (cmd),
        .stat        (stat),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_red   = m_data_reg[0];
    assign m_green = m_data_reg[1];
    assign m_blue  = m_data_reg[2];
    assign m_alpha = m_data_reg[3];

    a_eval_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_EVAL) |=> !s_ready)
        else $error("input ready right after an evaluate transaction");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwrites an untaken transaction");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(out_load))
        else $error("output valid without a result load");

endmodule

>>> rtl/hcg_ram.sv
module hcg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/hcg_dp.sv
module hcg_dp
    import hcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_color,
    input  logic               wr_alpha,
    input  logic [KeyAw-1:0]   wr_addr,
    input  logic signed [31:0] key_time,
    input  logic signed [31:0] key_red,
    input  logic signed [31:0] key_green,
    input  logic signed [31:0] key_blue,
    input  logic signed [31:0] key_alpha,
    input  logic signed [31:0] in_tangent,
    input  logic signed [31:0] out_tangent,
    input  logic signed [31:0] eval_time,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    output logic [3:0][31:0]   res
);

    logic [191:0] color_rdata;
    logic [127:0] alpha_rdata;
    key_row_t     color_wrow;
    key_row_t     rd_row;

    key_row_t            prev_reg;
    key_row_t            cur_reg;
    logic signed [31:0]  t_reg;
    logic [33:0]         rem_reg;
    logic [16:0]         u_reg;
    logic [16:0]         u2_reg;
    logic [16:0]         u3_reg;
    logic signed [49:0]  m0_reg;
    logic signed [49:0]  m1_reg;
    logic signed [67:0]  p_reg;
    mul_code_t           p_code_reg;
    logic                p_vld_reg;
    logic signed [71:0]  acc_reg;
    logic [3:0][31:0]    res_reg;

    logic signed [32:0] dt;
    logic signed [32:0] diff;
    logic [33:0]        rem_sub;
    logic signed [19:0] uz, u2z, u3z;
    logic signed [19:0] h00, h10, h01, h11;
    logic signed [33:0] a_op, b_op;
    logic signed [55:0] acc_sh;
    logic [31:0]        acc_sat;
    key_row_t           src_row;

    always_comb begin
        color_wrow.tkey   = key_time;
        color_wrow.val[0] = key_red;
        color_wrow.val[1] = key_green;
        color_wrow.val[2] = key_blue;
        color_wrow.in_s   = in_tangent;
        color_wrow.out_s  = out_tangent;
    end

    hcg_ram #(.WIDTH(192), .DEPTH(MaxKeys)) u_color_ram (
        .aclk  (aclk),
        .we    (wr_color),
        .waddr (wr_addr),
        .wdata (color_wrow),
        .re    (cmd.rd_en && !cmd.tbl),
        .raddr (cmd.rd_addr),
        .rdata (color_rdata)
    );

    hcg_ram #(.WIDTH(128), .DEPTH(MaxKeys)) u_alpha_ram (
        .aclk  (aclk),
        .we    (wr_alpha),
        .waddr (wr_addr),
        .wdata ({key_time, key_alpha, in_tangent, out_tangent}),
        .re    (cmd.rd_en && cmd.tbl),
        .raddr (cmd.rd_addr),
        .rdata (alpha_rdata)
    );

    always_comb begin
        if (cmd.tbl) begin
            rd_row.tkey   = alpha_rdata[127:96];
            rd_row.val[0] = alpha_rdata[95:64];
            rd_row.val[1] = '0;
            rd_row.val[2] = '0;
            rd_row.in_s   = alpha_rdata[63:32];
            rd_row.out_s  = alpha_rdata[31:0];
        end else begin
            rd_row = key_row_t'(color_rdata);
        end
    end

    // segment and search compares
    always_comb begin
        stat.t_le_rd   = t_reg <= $signed(rd_row.tkey);
        stat.t_ge_rd   = t_reg >= $signed(rd_row.tkey);
        stat.seg_hit   = ($signed(cur_reg.tkey) <= t_reg) && (t_reg <= $signed(rd_row.tkey));
        dt   = 33'($signed(cur_reg.tkey)) - 33'($signed(prev_reg.tkey));
        diff = 33'(t_reg) - 33'($signed(prev_reg.tkey));
        stat.seg_short = 34'(dt) < SegEps;
        rem_sub = rem_reg - {1'b0, dt[32:0]};
    end

    // Hermite basis
    always_comb begin
        uz  = 20'(u_reg);
        u2z = 20'(u2_reg);
        u3z = 20'(u3_reg);
        h00 = u3z + u3z - (u2z + u2z + u2z) + 20'sd65536;
        h10 = u3z - (u2z + u2z) + uz;
        h01 = (u2z + u2z + u2z) - (u3z + u3z);
        h11 = u3z - u2z;
    end

    always_comb begin
        a_op = '0;
        b_op = '0;
        case (cmd.mul_code)
            MS_UU: begin
                a_op = 34'(u_reg);
                b_op = 34'(u_reg);
            end
            MS_U2U: begin
                a_op = 34'(u2_reg);
                b_op = 34'(u_reg);
            end
            MS_S0DT: begin
                a_op = 34'($signed(prev_reg.out_s));
                b_op = 34'(dt);
            end
            MS_S1DT: begin
                a_op = 34'($signed(cur_reg.in_s));
                b_op = 34'(dt);
            end
            MS_H00V0: begin
                a_op = 34'(h00);
                b_op = 34'($signed(prev_reg.val[cmd.ch]));
            end
            MS_H01V1: begin
                a_op = 34'(h01);
                b_op = 34'($signed(cur_reg.val[cmd.ch]));
            end
            MS_H10M0L: begin
                a_op = 34'(h10);
                b_op = {2'b00, m0_reg[31:0]};
            end
            MS_H10M0H: begin
                a_op = 34'(h10);
                b_op = 34'($signed(m0_reg[49:32]));
            end
            MS_H11M1L: begin
                a_op = 34'(h11);
                b_op = {2'b00, m1_reg[31:0]};
            end
            MS_H11M1H: begin
                a_op = 34'(h11);
                b_op = 34'($signed(m1_reg[49:32]));
            end
            default: begin
                a_op = '0;
                b_op = '0;
            end
        endcase
    end

    always_comb begin
        acc_sh = acc_reg[71:16];
        if (acc_sh > 56'sd2147483647) begin
            acc_sat = 32'h7fff_ffff;
        end else if (acc_sh < -56'sd2147483648) begin
            acc_sat = 32'h8000_0000;
        end else begin
            acc_sat = acc_sh[31:0];
        end
        src_row = (cmd.key_src == SRC_PREV) ? prev_reg : rd_row;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_vld_reg <= 1'b0;
        end else begin
            p_vld_reg <= cmd.mul_go;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.init_res) begin
            t_reg   <= eval_time;
            res_reg <= {4{QOne}};
        end
        if (cmd.load_row) begin
            prev_reg <= cur_reg;
            cur_reg  <= rd_row;
        end
        if (cmd.key_wr) begin
            if (cmd.tbl) begin
                res_reg[3] <= src_row.val[0];
            end else begin
                res_reg[0] <= src_row.val[0];
                res_reg[1] <= src_row.val[1];
                res_reg[2] <= src_row.val[2];
            end
        end
        if (cmd.acc_wr) begin
            res_reg[cmd.tbl ? 2'd3 : cmd.ch] <= acc_sat;
        end
        // restoring divide, one quotient bit a cycle
        if (cmd.div_start) begin
            rem_reg <= {1'b0, diff[32:0]};
            u_reg   <= '0;
        end else if (cmd.div_step) begin
            if (!rem_sub[33]) begin
                rem_reg <= {rem_sub[32:0], 1'b0};
                u_reg   <= {u_reg[15:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[32:0], 1'b0};
                u_reg   <= {u_reg[15:0], 1'b0};
            end
        end
        if (cmd.mul_go) begin
            p_reg      <= a_op * b_op;
            p_code_reg <= cmd.mul_code;
        end
        if (p_vld_reg) begin
            case (p_code_reg)
                MS_UU:     u2_reg  <= p_reg[32:16];
                MS_U2U:    u3_reg  <= p_reg[32:16];
                MS_S0DT:   m0_reg  <= p_reg[65:16];
                MS_S1DT:   m1_reg  <= p_reg[65:16];
                MS_H00V0:  acc_reg <= 72'(p_reg);
                MS_H10M0H, MS_H11M1H: acc_reg <= acc_reg + (72'(p_reg) <<< 32);
                default:   acc_reg <= acc_reg + 72'(p_reg);
            endcase
        end
    end

    assign res = res_reg;

endmodule

>>> rtl/hcg_ctrl.sv
module hcg_ctrl
    import hcg_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            eval_go,
    input  logic [CntW-1:0] color_cnt,
    input  logic [CntW-1:0] alpha_cnt,
    input  dp_stat_t        stat,
    input  logic            out_free,
    output dp_cmd_t         cmd,
    output logic            ctl_idle,
    output logic            out_load
);

    typedef enum logic [3:0] {
        S_IDLE, S_TBL, S_CHK0, S_CHKL, S_SCAN0, S_SCAN, S_SEG, S_DIV,
        S_PREP, S_PREPW, S_CHOP, S_CHOPW, S_ACCW, S_NEXT, S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic             tbl_reg, tbl_next;
    logic [KeyAw-1:0] idx_reg, idx_next;
    logic [4:0]       step_reg, step_next;
    logic [1:0]       ch_reg, ch_next;
    logic [CntW-1:0]  n_keys;
    logic [CntW-1:0]  n_last;

    function automatic logic [CntW-1:0] clamp_cnt(input logic [CntW-1:0] c);
        return (c > CntW'(MaxKeys)) ? CntW'(MaxKeys) : c;
    endfunction

    function automatic mul_code_t prep_code(input logic [4:0] s);
        case (s)
            5'd0:    return MS_UU;
            5'd1:    return MS_U2U;
            5'd2:    return MS_S0DT;
            default: return MS_S1DT;
        endcase
    endfunction

    function automatic mul_code_t chan_code(input logic [4:0] s);
        case (s)
            5'd0:    return MS_H00V0;
            5'd1:    return MS_H01V1;
            5'd2:    return MS_H10M0L;
            5'd3:    return MS_H10M0H;
            5'd4:    return MS_H11M1L;
            default: return MS_H11M1H;
        endcase
    endfunction

    always_comb begin
        n_keys = tbl_reg ? clamp_cnt(alpha_cnt) : clamp_cnt(color_cnt);
        n_last = n_keys - 1'b1;
    end

    always_comb begin
        state_next = state_reg;
        tbl_next   = tbl_reg;
        idx_next   = idx_reg;
        step_next  = step_reg;
        ch_next    = ch_reg;
        cmd        = '0;
        cmd.tbl    = tbl_reg;
        cmd.ch     = ch_reg;
        cmd.key_src  = SRC_RD;
        cmd.mul_code = MS_UU;
        out_load   = 1'b0;
        ctl_idle   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                ctl_idle = 1'b1;
                if (eval_go) begin
                    cmd.init_res = 1'b1;
                    tbl_next     = 1'b0;
                    state_next   = S_TBL;
                end
            end
            S_TBL: begin
                if (n_keys == '0) begin
                    state_next = S_NEXT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = '0;
                    state_next  = S_CHK0;
                end
            end
            S_CHK0: begin
                if (stat.t_le_rd) begin
                    cmd.key_wr = 1'b1;
                    state_next = S_NEXT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = n_last[KeyAw-1:0];
                    state_next  = S_CHKL;
                end
            end
            S_CHKL: begin
                if (stat.t_ge_rd) begin
                    cmd.key_wr = 1'b1;
                    state_next = S_NEXT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = '0;
                    state_next  = S_SCAN0;
                end
            end
            S_SCAN0: begin
                cmd.load_row = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_addr  = KeyAw'(1);
                idx_next     = KeyAw'(1);
                state_next   = S_SCAN;
            end
            S_SCAN: begin
                cmd.load_row = 1'b1;
                if (stat.seg_hit) begin
                    state_next = S_SEG;
                end else if (idx_reg == n_last[KeyAw-1:0]) begin
                    // unsorted keys: leave 1.0
                    state_next = S_NEXT;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_addr = idx_reg + 1'b1;
                    idx_next    = idx_reg + 1'b1;
                end
            end
            S_SEG: begin
                if (stat.seg_short) begin
                    cmd.key_wr  = 1'b1;
                    cmd.key_src = SRC_PREV;
                    state_next  = S_NEXT;
                end else begin
                    cmd.div_start = 1'b1;
                    step_next     = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (step_reg == 5'(DivSteps - 1)) begin
                    step_next  = '0;
                    state_next = S_PREP;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_PREP: begin
                cmd.mul_go   = 1'b1;
                cmd.mul_code = prep_code(step_reg);
                state_next   = S_PREPW;
            end
            S_PREPW: begin
                if (step_reg == 5'd3) begin
                    step_next  = '0;
                    ch_next    = '0;
                    state_next = S_CHOP;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_PREP;
                end
            end
            S_CHOP: begin
                cmd.mul_go   = 1'b1;
                cmd.mul_code = chan_code(step_reg);
                state_next   = S_CHOPW;
            end
            S_CHOPW: begin
                if (step_reg == 5'd5) begin
                    state_next = S_ACCW;
                end else begin
                    step_next  = step_reg + 1'b1;
                    state_next = S_CHOP;
                end
            end
            S_ACCW: begin
                cmd.acc_wr = 1'b1;
                if (tbl_reg || ch_reg == 2'd2) begin
                    state_next = S_NEXT;
                end else begin
                    ch_next    = ch_reg + 1'b1;
                    step_next  = '0;
                    state_next = S_CHOP;
                end
            end
            S_NEXT: begin
                if (!tbl_reg) begin
                    tbl_next   = 1'b1;
                    state_next = S_TBL;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            tbl_reg   <= 1'b0;
            idx_reg   <= '0;
            step_reg  <= '0;
            ch_reg    <= '0;
        end else begin
            state_reg <= state_next;
            tbl_reg   <= tbl_next;
            idx_reg   <= idx_next;
            step_reg  <= step_next;
            ch_reg    <= ch_next;
        end
    end

endmodule

>>> tb/tb_hermite_color_gradient_eval_core.sv
`timescale 1ns / 100ps

module tb_hermite_color_gradient_eval_core;
    import hcg_pkg::*;

    typedef int key_tbl_t [MaxKeys];

    typedef struct {
        opcode_t     opcode;
        logic [2:0]  key_index;
        logic [31:0] key_time;
        logic [31:0] key_red;
        logic [31:0] key_green;
        logic [31:0] key_blue;
        logic [31:0] key_alpha;
        logic [31:0] in_tangent;
        logic [31:0] out_tangent;
        logic [31:0] eval_time;
    } grad_item_t;

    typedef struct {
        logic [31:0] red;
        logic [31:0] green;
        logic [31:0] blue;
        logic [31:0] alpha;
    } rgba_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_opcode = '0;
    logic [2:0] s_key_index = '0;
    logic signed [31:0] s_key_time = '0;
    logic signed [31:0] s_key_red = '0;
    logic signed [31:0] s_key_green = '0;
    logic signed [31:0] s_key_blue = '0;
    logic signed [31:0] s_key_alpha = '0;
    logic signed [31:0] s_in_tangent = '0;
    logic signed [31:0] s_out_tangent = '0;
    logic signed [31:0] s_eval_time = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [31:0] m_red;
    logic signed [31:0] m_green;
    logic signed [31:0] m_blue;
    logic signed [31:0] m_alpha;

    hermite_color_gradient_eval_core i_dut (.*);

    always #4 aclk = ~aclk;

    grad_item_t pending_items[$];
    rgba_t      color_expect_q[$];
    int         err_cnt = 0;
    logic       in_took = 1'b0;
    logic       hold_req = 1'b0;

    // predicted block state
    key_tbl_t ck_time, ck_red, ck_green, ck_blue, ck_in, ck_out;
    key_tbl_t ak_time, ak_val, ak_in, ak_out;
    int       color_cnt = 0;
    int       alpha_cnt = 0;

    // times as generated, used to aim evaluations
    key_tbl_t gen_ctime, gen_atime;

    function automatic logic [31:0] sat32(longint x);
        if (x > 64'sd2147483647) return 32'h7fffffff;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    function automatic longint hermite_val(longint v0, longint v1, longint s0, longint s1,
                                           longint dt, longint u);
        longint u2, u3, h00, h10, h01, h11, m0, m1;
        u2  = (u * u) >>> 16;
        u3  = (u2 * u) >>> 16;
        h00 = 2 * u3 - 3 * u2 + 65536;
        h10 = u3 - 2 * u2 + u;
        h01 = -2 * u3 + 3 * u2;
        h11 = u3 - u2;
        m0  = (s0 * dt) >>> 16;
        m1  = (s1 * dt) >>> 16;
        return (h00 * v0 + h10 * m0 + h01 * v1 + h11 * m1) >>> 16;
    endfunction

    // 0: table gives 1.0, 1: copy key k, 2: interpolate segment k
    function automatic int find_segment(input key_tbl_t tt, input int cnt, input longint t,
                                        output int k, output longint u, output longint dt);
        int n;
        longint d;
        n = (cnt > MaxKeys) ? MaxKeys : cnt;
        k = 0; u = 0; dt = 0;
        if (n <= 0) return 0;
        if (t <= tt[0]) return 1;
        if (t >= tt[n-1]) begin
            k = n - 1;
            return 1;
        end
        for (int i = 0; i + 1 < n; i++) begin
            if (t >= tt[i] && t <= tt[i+1]) begin
                d = longint'(tt[i+1]) - longint'(tt[i]);
                k = i;
                if (d < SegEps) return 1;
                dt = d;
                u = ((t - longint'(tt[i])) <<< 16) / d;
                return 2;
            end
        end
        return 0;
    endfunction

    function automatic rgba_t predict_color(longint t);
        rgba_t res;
        int mode, k;
        longint u, dt, r, g, b, a;
        r = 65536; g = 65536; b = 65536; a = 65536;
        mode = find_segment(ck_time, color_cnt, t, k, u, dt);
        if (mode == 1) begin
            r = ck_red[k]; g = ck_green[k]; b = ck_blue[k];
        end else if (mode == 2) begin
            r = hermite_val(ck_red[k], ck_red[k+1], ck_out[k], ck_in[k+1], dt, u);
            g = hermite_val(ck_green[k], ck_green[k+1], ck_out[k], ck_in[k+1], dt, u);
            b = hermite_val(ck_blue[k], ck_blue[k+1], ck_out[k], ck_in[k+1], dt, u);
        end
        mode = find_segment(ak_time, alpha_cnt, t, k, u, dt);
        if (mode == 1) a = ak_val[k];
        else if (mode == 2) a = hermite_val(ak_val[k], ak_val[k+1], ak_out[k], ak_in[k+1], dt, u);
        res.red = sat32(r); res.green = sat32(g); res.blue = sat32(b); res.alpha = sat32(a);
        return res;
    endfunction

    // accept transactions and check results
    always @(posedge aclk) begin : monitor_proc
        rgba_t ex;
        in_took <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            case (opcode_t'(s_opcode))
                OP_WR_COLOR: begin
                    ck_time[s_key_index]  = s_key_time;
                    ck_red[s_key_index]   = s_key_red;
                    ck_green[s_key_index] = s_key_green;
                    ck_blue[s_key_index]  = s_key_blue;
                    ck_in[s_key_index]    = s_in_tangent;
                    ck_out[s_key_index]   = s_out_tangent;
                end
                OP_WR_ALPHA: begin
                    ak_time[s_key_index] = s_key_time;
                    ak_val[s_key_index]  = s_key_alpha;
                    ak_in[s_key_index]   = s_in_tangent;
                    ak_out[s_key_index]  = s_out_tangent;
                end
                OP_EVAL: color_expect_q.push_back(predict_color(longint'(s_eval_time)));
                default: ;
            endcase
        end
        if (aresetn && m_valid && m_ready) begin
            if (color_expect_q.size() == 0) begin
                $display("%0t: unexpected result r=%h g=%h b=%h a=%h",
                         $time, m_red, m_green, m_blue, m_alpha);
                err_cnt++;
            end else begin
                ex = color_expect_q.pop_front();
                if (m_red !== ex.red) begin
                    $display("%0t: red expected %h actual %h", $time, ex.red, m_red);
                    err_cnt++;
                end
                if (m_green !== ex.green) begin
                    $display("%0t: green expected %h actual %h", $time, ex.green, m_green);
                    err_cnt++;
                end
                if (m_blue !== ex.blue) begin
                    $display("%0t: blue expected %h actual %h", $time, ex.blue, m_blue);
                    err_cnt++;
                end
                if (m_alpha !== ex.alpha) begin
                    $display("%0t: alpha expected %h actual %h", $time, ex.alpha, m_alpha);
                    err_cnt++;
                end
            end
        end
    end

    int burst_left = 8;
    int gap_left = 0;

    // sender: bursts with random gaps
    always @(negedge aclk) begin : drive_proc
        grad_item_t it;
        if (aresetn && (!s_valid || in_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
                it = pending_items.pop_front();
                s_valid       <= 1'b1;
                s_opcode      <= it.opcode;
                s_key_index   <= it.key_index;
                s_key_time    <= it.key_time;
                s_key_red     <= it.key_red;
                s_key_green   <= it.key_green;
                s_key_blue    <= it.key_blue;
                s_key_alpha   <= it.key_alpha;
                s_in_tangent  <= it.in_tangent;
                s_out_tangent <= it.out_tangent;
                s_eval_time   <= it.eval_time;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    int ready_mode = 0;
    int mode_cnt = 0;
    int long_hold = 0;
    logic hold_done = 1'b0;

    // receiver: stall pattern changes every so often
    always @(negedge aclk) begin
        if (hold_req && !hold_done) begin
            hold_done <= 1'b1;
            long_hold <= 600;
            m_ready <= 1'b0;
        end else if (long_hold > 0) begin
            long_hold <= long_hold - 1;
            m_ready <= 1'b0;
        end else begin
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                default: m_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
        if (mode_cnt == 0) begin
            ready_mode <= $urandom_range(0, 2);
            mode_cnt <= $urandom_range(20, 150);
        end else begin
            mode_cnt <= mode_cnt - 1;
        end
    end

    function automatic logic [31:0] rand_value();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return 32'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
        endcase
    endfunction

    function automatic grad_item_t rand_item(opcode_t op);
        grad_item_t it;
        it.opcode = op;
        it.key_index = 3'($urandom);
        it.key_time = $urandom;
        it.key_red = rand_value();
        it.key_green = rand_value();
        it.key_blue = rand_value();
        it.key_alpha = rand_value();
        it.in_tangent = rand_value();
        it.out_tangent = rand_value();
        it.eval_time = $urandom;
        return it;
    endfunction

    task automatic push_key(opcode_t op, int idx, int tkey);
        grad_item_t it;
        it = rand_item(op);
        it.key_index = 3'(idx);
        it.key_time = tkey;
        if (op == OP_WR_COLOR) gen_ctime[idx] = tkey;
        else gen_atime[idx] = tkey;
        pending_items.push_back(it);
    endtask

    task automatic push_eval(int t);
        grad_item_t it;
        it = rand_item(OP_EVAL);
        it.eval_time = t;
        pending_items.push_back(it);
    endtask

    // styles: 0 sorted, 1 short gaps, 2 full range with extremes, 3 unsorted
    task automatic load_table(opcode_t op, int style);
        key_tbl_t tt;
        longint cur, span;
        int tmp;
        span = ($urandom_range(0, 2) == 0) ? 40 :
               ($urandom_range(0, 1) ? (1 << 18) : (1 << 28));
        cur = longint'(int'($urandom_range(0, 1 << 30))) - (1 << 29);
        for (int i = 0; i < MaxKeys; i++) begin
            case (style)
                1: cur += $urandom_range(0, 8);
                2, 3: cur = longint'(int'($urandom));
                default: cur += $urandom_range(1, span);
            endcase
            if (cur > 64'sd2147483647) cur = 64'sd2147483647;
            tt[i] = int'(cur);
        end
        if (style == 2) begin
            for (int i = 0; i < MaxKeys; i++)
                for (int j = 0; j + 1 < MaxKeys - i; j++)
                    if (tt[j] > tt[j+1]) begin
                        tmp = tt[j]; tt[j] = tt[j+1]; tt[j+1] = tmp;
                    end
            tt[0] = 32'h80000000;
            tt[MaxKeys-1] = 32'h7fffffff;
        end
        for (int i = 0; i < MaxKeys; i++) push_key(op, i, tt[i]);
    endtask

    function automatic int aim_time();
        key_tbl_t tt;
        int i;
        longint lo, hi;
        tt = $urandom_range(0, 1) ? gen_ctime : gen_atime;
        i = $urandom_range(0, MaxKeys - 2);
        lo = tt[i];
        hi = tt[i+1];
        case ($urandom_range(0, 9))
            0: return tt[$urandom_range(0, MaxKeys - 1)];
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2, 3: return $urandom;
            default: begin
                if (hi <= lo) return int'(lo);
                return int'(lo + longint'({$urandom, $urandom} % (hi - lo + 1)));
            end
        endcase
    endfunction

    task automatic wait_idle();
        while (pending_items.size() != 0 || s_valid || color_expect_q.size() != 0)
            @(posedge aclk);
        repeat (300) @(posedge aclk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic set_counts(int cc, int ac);
        apb_write(3'(REG_COLOR_CNT) << 2, cc);
        color_cnt = cc;
        apb_write(3'(REG_ALPHA_CNT) << 2, ac);
        alpha_cnt = ac;
    endtask

    initial begin : stim_proc
        int n_items, phase_len, sel;
        int count_pick [8] = '{0, 1, 2, 3, 5, 8, 9, 15};
        grad_item_t it;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty tables evaluate to white; unused opcode is dropped
        push_eval(32'h80000000);
        push_eval(32'h7fffffff);
        pending_items.push_back(rand_item(OP_NONE));
        load_table(OP_WR_COLOR, 0);
        load_table(OP_WR_ALPHA, 2);
        wait_idle();
        set_counts(8, 8);
        push_eval(32'h80000000);
        push_eval(32'h7fffffff);
        push_eval(gen_ctime[0]);
        push_eval(gen_ctime[7]);
        push_eval(gen_atime[3]);
        for (int i = 0; i < 4; i++) push_eval(aim_time());
        wait_idle();
        // short segments on color, unsorted alpha
        load_table(OP_WR_COLOR, 1);
        load_table(OP_WR_ALPHA, 3);
        for (int i = 0; i < 6; i++) push_eval(aim_time());
        wait_idle();
        set_counts(15, 0);
        push_eval(aim_time());
        wait_idle();

        n_items = 0;
        for (int ph = 0; n_items < 1450; ph++) begin
            set_counts(count_pick[$urandom_range(0, 7)], count_pick[$urandom_range(0, 7)]);
            sel = $urandom_range(0, 9);
            load_table(OP_WR_COLOR, sel < 7 ? 0 : sel - 6);
            sel = $urandom_range(0, 9);
            load_table(OP_WR_ALPHA, sel < 7 ? 0 : sel - 6);
            n_items += 2 * MaxKeys;
            if (ph == 3) hold_req = 1'b1;
            phase_len = $urandom_range(60, 140);
            for (int i = 0; i < phase_len; i++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70) begin
                    push_eval(aim_time());
                    n_items++;
                end else if (sel < 90) begin
                    // rewrite a key in place, keeping its time
                    if ($urandom_range(0, 1)) begin
                        sel = $urandom_range(0, MaxKeys - 1);
                        push_key(OP_WR_COLOR, sel, gen_ctime[sel]);
                    end else begin
                        sel = $urandom_range(0, MaxKeys - 1);
                        push_key(OP_WR_ALPHA, sel, gen_atime[sel]);
                    end
                    n_items++;
                end else if (sel < 95) begin
                    pending_items.push_back(rand_item(OP_NONE));
                end else begin
                    it = rand_item($urandom_range(0, 1) ? OP_WR_COLOR : OP_WR_ALPHA);
                    push_key(it.opcode, it.key_index, it.key_time);
                    n_items++;
                end
            end
            wait_idle();
        end

        if (err_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
